// ===== src/gaps_pkg.sv =====
// ----------------------------------------------------------------------------
// gaps_pkg
// Shared types for the grid path search: op and status codes, move
// directions, controller states and the controller/datapath command bundle.
// ----------------------------------------------------------------------------
package gaps_pkg;

    localparam int GRID_SIDE_DEF = 16;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_SEARCH = 2'd1,
        OP_READ   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_FOUND        = 2'd0,
        ST_SAME         = 2'd1,
        ST_GOAL_BLOCKED = 2'd2,
        ST_NO_PATH      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        DIR_XP = 2'd0,
        DIR_XM = 2'd1,
        DIR_YM = 2'd2,
        DIR_YP = 2'd3
    } dir_t;

    typedef enum logic [1:0] {
        NRD_SCAN   = 2'd0,
        NRD_NB     = 2'd1,
        NRD_TRACE  = 2'd2,
        NRD_CURSOR = 2'd3
    } nrd_sel_t;

    typedef enum logic [4:0] {
        S_WCLR,
        S_IDLE,
        S_LOAD,
        S_NOP,
        S_SRCH0,
        S_SRCH1,
        S_NCLR,
        S_PLACE,
        S_SCAN,
        S_SCAN_W,
        S_DECIDE,
        S_NB_RD,
        S_NB_UPD,
        S_TR_CHK,
        S_TR_STEP,
        S_R_RD,
        S_R_EMIT
    } state_t;

    typedef struct packed {
        logic     capture;
        logic     wclr;
        logic     load_wr;
        logic     code_latch;
        logic     nclr;
        logic     place;
        logic     scan_init;
        logic     scan_rd;
        logic     close_best;
        logic     nb_rd;
        logic     nb_upd;
        logic     trace_init;
        logic     trace_step;
        nrd_sel_t nrd_sel;
        logic     emit_zero;
        logic     emit_fail;
        logic     emit_found;
        logic     emit_step;
    } cmd_t;

    typedef struct packed {
        logic cnt_last;
        logic early_fail;
        logic best_valid;
        logic best_is_goal;
        logic k_last;
        logic tr_stop;
        logic steps_zero;
    } sts_t;

endpackage

// ===== src/grid_astar_path_search_top.sv =====
// Every search expansion scans all C = GRID_SIDE^2 node memory entries
// through one read port. Throughput: one item at a time.
// Reset: a clearing pass zeroes the walk map; busy stays high.
// The receiver cannot stall: done marks each result for one cycle.
// ----------------------------------------------------------------------------
// grid_astar_path_search_top
// Grid A* path search, 4-connected with Manhattan estimate.
// ----------------------------------------------------------------------------
module grid_astar_path_search_top #(
    parameter int GRID_SIDE = gaps_pkg::GRID_SIDE_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] op,
    input  logic [3:0] cell_x,
    input  logic [3:0] cell_y,
    input  logic       walkable,
    input  logic [3:0] start_x,
    input  logic [3:0] start_y,
    input  logic [3:0] goal_x,
    input  logic [3:0] goal_y,
    output logic       done,
    output logic [1:0] status,
    output logic [7:0] path_length,
    output logic [3:0] step_x,
    output logic [3:0] step_y,
    output logic       step_valid,
    output logic       step_last
);
    import gaps_pkg::*;

    cmd_t cmd;
    sts_t sts;

    gaps_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    gaps_datapath #(
        .GRID_SIDE (GRID_SIDE)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cell_x      (cell_x),
        .cell_y      (cell_y),
        .walkable    (walkable),
        .start_x     (start_x),
        .start_y     (start_y),
        .goal_x      (goal_x),
        .goal_y      (goal_y),
        .done        (done),
        .status      (status),
        .path_length (path_length),
        .step_x      (step_x),
        .step_y      (step_y),
        .step_valid  (step_valid),
        .step_last   (step_last)
    );

endmodule

// ===== src/gaps_ctrl.sv =====
// ----------------------------------------------------------------------------
// gaps_ctrl
// Sequencer for the path search: map clear after reset, load, search
// (node clear, open-set scan, expansion, back trace) and path reads.
// ----------------------------------------------------------------------------
module gaps_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [1:0]     op,
    input  gaps_pkg::sts_t sts,
    output gaps_pkg::cmd_t cmd,
    output logic           busy
);
    import gaps_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_WCLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_WCLR:
            begin
                if (sts.cnt_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    case (op_t'(op))
                        OP_LOAD:   state_next = S_LOAD;
                        OP_SEARCH: state_next = S_SRCH0;
                        OP_READ:   state_next = S_R_RD;
                        default:   state_next = S_NOP;
                    endcase
                end
            end
            S_LOAD:  state_next = S_IDLE;
            S_NOP:   state_next = S_IDLE;
            S_SRCH0: state_next = S_SRCH1;
            S_SRCH1:
            begin
                state_next = sts.early_fail ? S_IDLE : S_NCLR;
            end
            S_NCLR:
            begin
                if (sts.cnt_last)
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE: state_next = S_SCAN;
            S_SCAN:
            begin
                if (sts.cnt_last)
                begin
                    state_next = S_SCAN_W;
                end
            end
            S_SCAN_W: state_next = S_DECIDE;
            S_DECIDE:
            begin
                if (!sts.best_valid)
                begin
                    state_next = S_IDLE;
                end
                else if (sts.best_is_goal)
                begin
                    state_next = S_TR_CHK;
                end
                else
                begin
                    state_next = S_NB_RD;
                end
            end
            S_NB_RD: state_next = S_NB_UPD;
            S_NB_UPD:
            begin
                state_next = sts.k_last ? S_SCAN : S_NB_RD;
            end
            S_TR_CHK:
            begin
                state_next = sts.tr_stop ? S_IDLE : S_TR_STEP;
            end
            S_TR_STEP: state_next = S_TR_CHK;
            S_R_RD:
            begin
                state_next = sts.steps_zero ? S_IDLE : S_R_EMIT;
            end
            S_R_EMIT: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.nrd_sel = NRD_SCAN;
        case (state_reg)
            S_WCLR:  cmd.wclr = 1'b1;
            S_IDLE:  cmd.capture = start;
            S_LOAD:
            begin
                cmd.load_wr   = 1'b1;
                cmd.emit_zero = 1'b1;
            end
            S_NOP:   cmd.emit_zero = 1'b1;
            S_SRCH0: cmd = '0;
            S_SRCH1:
            begin
                cmd.code_latch = 1'b1;
                cmd.emit_fail  = sts.early_fail;
            end
            S_NCLR:  cmd.nclr = 1'b1;
            S_PLACE:
            begin
                cmd.place     = 1'b1;
                cmd.scan_init = 1'b1;
            end
            S_SCAN:   cmd.scan_rd = 1'b1;
            S_SCAN_W: cmd = '0;
            S_DECIDE:
            begin
                cmd.emit_fail  = !sts.best_valid;
                cmd.trace_init = sts.best_valid && sts.best_is_goal;
                cmd.close_best = sts.best_valid && !sts.best_is_goal;
            end
            S_NB_RD:
            begin
                cmd.nb_rd   = 1'b1;
                cmd.nrd_sel = NRD_NB;
            end
            S_NB_UPD:
            begin
                cmd.nb_upd    = 1'b1;
                cmd.scan_init = 1'b1;
            end
            S_TR_CHK:
            begin
                cmd.nrd_sel    = NRD_TRACE;
                cmd.emit_found = sts.tr_stop;
            end
            S_TR_STEP: cmd.trace_step = 1'b1;
            S_R_RD:
            begin
                cmd.nrd_sel   = NRD_CURSOR;
                cmd.emit_zero = sts.steps_zero;
            end
            S_R_EMIT: cmd.emit_step = 1'b1;
            default:  cmd = '0;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== src/gaps_datapath.sv =====
// ----------------------------------------------------------------------------
// gaps_datapath
// Walk map and node memories, scan/best selection, neighbour update,
// back trace, path read cursor and the result registers.
// ----------------------------------------------------------------------------
module gaps_datapath #(
    parameter int GRID_SIDE = gaps_pkg::GRID_SIDE_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  gaps_pkg::cmd_t cmd,
    output gaps_pkg::sts_t sts,
    input  logic [3:0]     cell_x,
    input  logic [3:0]     cell_y,
    input  logic           walkable,
    input  logic [3:0]     start_x,
    input  logic [3:0]     start_y,
    input  logic [3:0]     goal_x,
    input  logic [3:0]     goal_y,
    output logic           done,
    output logic [1:0]     status,
    output logic [7:0]     path_length,
    output logic [3:0]     step_x,
    output logic [3:0]     step_y,
    output logic           step_valid,
    output logic           step_last
);
    import gaps_pkg::*;

    localparam int CELLS = GRID_SIDE * GRID_SIDE;
    localparam int CW    = $clog2(GRID_SIDE);
    localparam int IW    = $clog2(CELLS);
    localparam int GW    = IW + 1;
    localparam int FW    = IW + 2;
    localparam int TW    = IW + 3;
    localparam int LW    = IW + 1;

    typedef logic [CW-1:0] coord_t;
    typedef logic [IW-1:0] index_t;

    typedef struct packed {
        logic          open;
        logic          closed;
        logic [GW-1:0] g;
        logic [FW-1:0] f;
        logic [1:0]    dir;
        logic [TW-1:0] stamp;
    } node_t;

    typedef struct packed {
        logic   out;
        coord_t x;
        coord_t y;
    } back_t;

    function automatic index_t cell_idx(input coord_t x, input coord_t y);
        return IW'(int'(x) * GRID_SIDE + int'(y));
    endfunction

    function automatic logic [CW:0] manhattan(input coord_t ax, input coord_t ay,
                                              input coord_t bx, input coord_t by);
        coord_t dx;
        coord_t dy;
        dx = (ax > bx) ? ax - bx : bx - ax;
        dy = (ay > by) ? ay - by : by - ay;
        return {1'b0, dx} + {1'b0, dy};
    endfunction

    function automatic back_t step_back(input coord_t x, input coord_t y,
                                        input logic [1:0] d);
        back_t r;
        r.out = 1'b0;
        r.x   = x;
        r.y   = y;
        case (dir_t'(d))
            DIR_XP:
            begin
                r.out = (x == '0);
                r.x   = x - 1'b1;
            end
            DIR_XM:
            begin
                r.out = (x == CW'(GRID_SIDE - 1));
                r.x   = x + 1'b1;
            end
            DIR_YM:
            begin
                r.out = (y == CW'(GRID_SIDE - 1));
                r.y   = y + 1'b1;
            end
            DIR_YP:
            begin
                r.out = (y == '0);
                r.y   = y - 1'b1;
            end
            default: r.out = 1'b1;
        endcase
        return r;
    endfunction

    // captured item fields
    logic [3:0] cap_cx_reg, cap_cy_reg, cap_sx_reg, cap_sy_reg, cap_gx_reg, cap_gy_reg;
    logic       cap_walk_reg;

    // memories
    logic  walk_mem [CELLS];
    node_t node_mem [CELLS];
    logic  walk_q;
    node_t node_q;

    // sweep counter
    coord_t cnt_x_reg, cnt_y_reg;

    // best open entry
    logic          best_valid_reg;
    coord_t        best_x_reg, best_y_reg;
    logic [GW-1:0] best_g_reg;
    logic [FW-1:0] best_f_reg;
    logic [1:0]    best_dir_reg;
    logic [TW-1:0] best_stamp_reg;
    logic          pend_reg;
    coord_t        px_reg, py_reg;

    // neighbour
    logic [1:0]    k_reg;
    coord_t        nb_x_reg, nb_y_reg;
    logic          nb_in_reg;
    logic [TW-1:0] stamp_reg;

    // trace and read cursor
    coord_t        tr_x_reg, tr_y_reg;
    logic [LW-1:0] guard_reg;
    logic          tr_out_reg;
    coord_t        cur_x_reg, cur_y_reg;
    logic [LW-1:0] steps_reg;
    logic [1:0]    code_reg;

    // results
    logic       done_reg;
    logic [1:0] status_reg;
    logic [7:0] len_reg;
    logic [3:0] sx_out_reg, sy_out_reg;
    logic       sv_reg, sl_reg;

    coord_t sx_c, sy_c, gx_c, gy_c, cx_c, cy_c;
    logic   goal_in, start_in, cell_in, same;
    coord_t nb_x, nb_y;
    logic   nb_in;
    logic   cnt_adv, cnt_last;
    logic          walk_we, walk_wd;
    index_t        walk_wa, walk_ra;
    logic          node_we;
    index_t        node_wa, node_ra;
    node_t         node_wd;
    logic [GW-1:0] ng;
    logic [FW-1:0] nf;
    logic          nb_take;
    logic          better;
    back_t         tr_back, cur_back;
    logic [1:0]    code_c;

    assign sx_c = CW'(cap_sx_reg);
    assign sy_c = CW'(cap_sy_reg);
    assign gx_c = CW'(cap_gx_reg);
    assign gy_c = CW'(cap_gy_reg);
    assign cx_c = CW'(cap_cx_reg);
    assign cy_c = CW'(cap_cy_reg);

    assign goal_in  = (int'(cap_gx_reg) < GRID_SIDE) && (int'(cap_gy_reg) < GRID_SIDE);
    assign start_in = (int'(cap_sx_reg) < GRID_SIDE) && (int'(cap_sy_reg) < GRID_SIDE);
    assign cell_in  = (int'(cap_cx_reg) < GRID_SIDE) && (int'(cap_cy_reg) < GRID_SIDE);
    assign same     = (cap_sx_reg == cap_gx_reg) && (cap_sy_reg == cap_gy_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cap_cx_reg   <= cell_x;
            cap_cy_reg   <= cell_y;
            cap_walk_reg <= walkable;
            cap_sx_reg   <= start_x;
            cap_sy_reg   <= start_y;
            cap_gx_reg   <= goal_x;
            cap_gy_reg   <= goal_y;
        end
    end

    // sweep counter wraps back to zero after the last cell
    assign cnt_adv  = cmd.wclr || cmd.nclr || cmd.scan_rd;
    assign cnt_last = (cnt_x_reg == CW'(GRID_SIDE - 1)) && (cnt_y_reg == CW'(GRID_SIDE - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_x_reg <= '0;
            cnt_y_reg <= '0;
        end
        else if (cnt_adv)
        begin
            if (cnt_y_reg == CW'(GRID_SIDE - 1))
            begin
                cnt_y_reg <= '0;
                cnt_x_reg <= (cnt_x_reg == CW'(GRID_SIDE - 1)) ? '0 : cnt_x_reg + 1'b1;
            end
            else
            begin
                cnt_y_reg <= cnt_y_reg + 1'b1;
            end
        end
    end

    // neighbour of the best entry
    always_comb
    begin
        nb_x  = best_x_reg;
        nb_y  = best_y_reg;
        nb_in = 1'b1;
        case (dir_t'(k_reg))
            DIR_XP:
            begin
                nb_in = (best_x_reg != CW'(GRID_SIDE - 1));
                nb_x  = best_x_reg + 1'b1;
            end
            DIR_XM:
            begin
                nb_in = (best_x_reg != '0);
                nb_x  = best_x_reg - 1'b1;
            end
            DIR_YM:
            begin
                nb_in = (best_y_reg != '0);
                nb_y  = best_y_reg - 1'b1;
            end
            DIR_YP:
            begin
                nb_in = (best_y_reg != CW'(GRID_SIDE - 1));
                nb_y  = best_y_reg + 1'b1;
            end
            default: nb_in = 1'b0;
        endcase
    end

    // walk map port
    always_comb
    begin
        walk_we = 1'b0;
        walk_wd = 1'b0;
        walk_wa = cell_idx(cnt_x_reg, cnt_y_reg);
        if (cmd.wclr)
        begin
            walk_we = 1'b1;
        end
        else if (cmd.load_wr && cell_in)
        begin
            walk_we = 1'b1;
            walk_wa = cell_idx(cx_c, cy_c);
            walk_wd = cap_walk_reg;
        end
        walk_ra = cmd.nb_rd ? cell_idx(nb_x, nb_y) : cell_idx(gx_c, gy_c);
    end

    always_ff @(posedge clk)
    begin
        if (walk_we)
        begin
            walk_mem[walk_wa] <= walk_wd;
        end
        walk_q <= walk_mem[walk_ra];
    end

    // node memory port
    assign ng      = best_g_reg + 1'b1;
    assign nf      = FW'(ng) + FW'(manhattan(nb_x_reg, nb_y_reg, gx_c, gy_c));
    assign nb_take = nb_in_reg && walk_q && !node_q.closed && (!node_q.open || ng < node_q.g);

    always_comb
    begin
        node_we = 1'b0;
        node_wa = cell_idx(cnt_x_reg, cnt_y_reg);
        node_wd = '0;
        if (cmd.nclr)
        begin
            node_we = 1'b1;
        end
        else if (cmd.place)
        begin
            node_we      = 1'b1;
            node_wa      = cell_idx(sx_c, sy_c);
            node_wd.open = 1'b1;
            node_wd.f    = FW'(manhattan(sx_c, sy_c, gx_c, gy_c));
            node_wd.dir  = DIR_XP;
        end
        else if (cmd.close_best)
        begin
            node_we        = 1'b1;
            node_wa        = cell_idx(best_x_reg, best_y_reg);
            node_wd.closed = 1'b1;
            node_wd.g      = best_g_reg;
            node_wd.f      = best_f_reg;
            node_wd.dir    = best_dir_reg;
            node_wd.stamp  = best_stamp_reg;
        end
        else if (cmd.nb_upd && nb_take)
        begin
            node_we       = 1'b1;
            node_wa       = cell_idx(nb_x_reg, nb_y_reg);
            node_wd.open  = 1'b1;
            node_wd.g     = ng;
            node_wd.f     = nf;
            node_wd.dir   = k_reg;
            node_wd.stamp = stamp_reg;
        end
        case (cmd.nrd_sel)
            NRD_SCAN:   node_ra = cell_idx(cnt_x_reg, cnt_y_reg);
            NRD_NB:     node_ra = cell_idx(nb_x, nb_y);
            NRD_TRACE:  node_ra = cell_idx(tr_x_reg, tr_y_reg);
            NRD_CURSOR: node_ra = cell_idx(cur_x_reg, cur_y_reg);
            default:    node_ra = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_wa] <= node_wd;
        end
        node_q <= node_mem[node_ra];
    end

    // open-set scan
    assign better = pend_reg && node_q.open &&
                    (!best_valid_reg || node_q.f < best_f_reg ||
                     (node_q.f == best_f_reg && node_q.stamp > best_stamp_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg       <= 1'b0;
            best_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= cmd.scan_rd;
            if (cmd.scan_init)
            begin
                best_valid_reg <= 1'b0;
            end
            else if (better)
            begin
                best_valid_reg <= 1'b1;
            end
        end
    end

    // early search outcome
    always_comb
    begin
        if (same)
        begin
            code_c = ST_SAME;
        end
        else if (!goal_in || !walk_q)
        begin
            code_c = ST_GOAL_BLOCKED;
        end
        else
        begin
            code_c = ST_NO_PATH;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg <= cnt_x_reg;
        py_reg <= cnt_y_reg;
        if (better)
        begin
            best_x_reg     <= px_reg;
            best_y_reg     <= py_reg;
            best_g_reg     <= node_q.g;
            best_f_reg     <= node_q.f;
            best_dir_reg   <= node_q.dir;
            best_stamp_reg <= node_q.stamp;
        end
        if (cmd.nb_rd)
        begin
            nb_x_reg  <= nb_x;
            nb_y_reg  <= nb_y;
            nb_in_reg <= nb_in;
        end
        if (cmd.code_latch)
        begin
            code_reg <= code_c;
        end
    end

    // expansion counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg     <= '0;
            stamp_reg <= '0;
        end
        else
        begin
            if (cmd.close_best)
            begin
                k_reg <= '0;
            end
            else if (cmd.nb_upd)
            begin
                k_reg <= k_reg + 1'b1;
            end
            if (cmd.place)
            begin
                stamp_reg <= TW'(1);
            end
            else if (cmd.nb_upd && nb_take)
            begin
                stamp_reg <= stamp_reg + 1'b1;
            end
        end
    end

    // back trace from the goal
    assign tr_back  = step_back(tr_x_reg, tr_y_reg, node_q.dir);
    assign cur_back = step_back(cur_x_reg, cur_y_reg, node_q.dir);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            guard_reg  <= '0;
            tr_out_reg <= 1'b0;
        end
        else if (cmd.trace_init)
        begin
            guard_reg  <= '0;
            tr_out_reg <= 1'b0;
        end
        else if (cmd.trace_step)
        begin
            guard_reg  <= guard_reg + 1'b1;
            tr_out_reg <= tr_back.out;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.trace_init)
        begin
            tr_x_reg <= gx_c;
            tr_y_reg <= gy_c;
        end
        else if (cmd.trace_step)
        begin
            tr_x_reg <= tr_back.x;
            tr_y_reg <= tr_back.y;
        end
    end

    // read cursor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_reg <= '0;
            cur_x_reg <= '0;
            cur_y_reg <= '0;
        end
        else if (cmd.emit_fail)
        begin
            steps_reg <= '0;
        end
        else if (cmd.emit_found)
        begin
            steps_reg <= guard_reg;
            cur_x_reg <= gx_c;
            cur_y_reg <= gy_c;
        end
        else if (cmd.emit_step)
        begin
            steps_reg <= cur_back.out ? '0 : steps_reg - 1'b1;
            cur_x_reg <= cur_back.x;
            cur_y_reg <= cur_back.y;
        end
    end

    // result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit_zero || cmd.emit_fail || cmd.emit_found || cmd.emit_step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_zero || cmd.emit_fail || cmd.emit_found || cmd.emit_step)
        begin
            status_reg <= ST_FOUND;
            len_reg    <= '0;
            sx_out_reg <= '0;
            sy_out_reg <= '0;
            sv_reg     <= 1'b0;
            sl_reg     <= 1'b0;
            if (cmd.emit_fail)
            begin
                status_reg <= cmd.code_latch ? code_c : code_reg;
            end
            else if (cmd.emit_found)
            begin
                len_reg <= (int'(guard_reg) > 255) ? 8'd255 : 8'(guard_reg);
            end
            else if (cmd.emit_step)
            begin
                sx_out_reg <= 4'(cur_x_reg);
                sy_out_reg <= 4'(cur_y_reg);
                sv_reg     <= 1'b1;
                sl_reg     <= (steps_reg == LW'(1));
            end
        end
    end

    assign sts.cnt_last     = cnt_last;
    assign sts.early_fail   = same || !goal_in || !walk_q || !start_in;
    assign sts.best_valid   = best_valid_reg;
    assign sts.best_is_goal = (best_x_reg == gx_c) && (best_y_reg == gy_c);
    assign sts.k_last       = (k_reg == 2'(DIR_YP));
    assign sts.tr_stop      = tr_out_reg || ((tr_x_reg == sx_c) && (tr_y_reg == sy_c)) ||
                              (guard_reg == LW'(CELLS));
    assign sts.steps_zero   = (steps_reg == '0);

    assign done        = done_reg;
    assign status      = status_reg;
    assign path_length = len_reg;
    assign step_x      = sx_out_reg;
    assign step_y      = sy_out_reg;
    assign step_valid  = sv_reg;
    assign step_last   = sl_reg;

endmodule

// ===== src/gaps_checker.sv =====
// ----------------------------------------------------------------------------
// gaps_checker
// Port-level checks on item flow and result field consistency.
// ----------------------------------------------------------------------------
module gaps_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [1:0] status,
    input logic [7:0] path_length,
    input logic       step_valid,
    input logic       step_last
);
    import gaps_pkg::*;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("item accepted but block not busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while still busy");

    a_step_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && step_valid) |-> (status == ST_FOUND && path_length == 8'd0))
        else $error("path step with search fields set");

    a_fail_len: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_FOUND) |-> (path_length == 8'd0 && !step_valid))
        else $error("failed search with nonzero length");

    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (done && step_last) |-> step_valid)
        else $error("last step flag without step");

endmodule

bind grid_astar_path_search_top gaps_checker u_gaps_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .path_length (path_length),
    .step_valid  (step_valid),
    .step_last   (step_last)
);
